/* rtl/core/mprq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mprq_pkg
// Shared types and codes for the multilevel priority ring queue.
// ----------------------------------------------------------------------------
package mprq_pkg;

    localparam int CFG_W   = 4;
    localparam int DATA_W  = 32;
    localparam int PRIO_W  = 4;
    localparam int LEVEL_W = 4;
    // comparison width for index arithmetic, holds any size up to 16
    localparam int CMP_W   = 5;

    localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

endpackage : mprq_pkg
`default_nettype wire

/* rtl/core/multilevel_priority_ring_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_priority_ring_queue_core
// Priority queue built from one circular ring per priority level.
// ----------------------------------------------------------------------------
// The queue takes one insert or delete transaction per clock cycle while the
// output is not stalled, and returns exactly one result per transaction in
// order. In the accept cycle the per-level head, tail and empty flags held in
// flip-flops are updated and the ring memory access is issued, so the
// registered read data of the single ring RAM (MAX_SIZE*MAX_SIZE words) is
// back at the accepting edge. The result passes from the lookup stage
// registers into the output register once that register is free. Since
// every transaction touches the RAM in its own accept cycle only, a delete that
// follows an insert to the same slot reads the freshly written word. The ring
// RAM needs no clearing after reset. The size register may only be written
// while no transaction is in flight.
module multilevel_priority_ring_queue_core
    import mprq_pkg::*;
#(
    parameter int MAX_SIZE = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                action,
    input  wire logic [PRIO_W-1:0]   priority_req,
    input  wire logic signed [DATA_W-1:0] value,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] removed_value,
    output logic [LEVEL_W-1:0]       removed_level
);

    localparam int IDX_W  = $clog2(MAX_SIZE);
    localparam int ADDR_W = $clog2(MAX_SIZE * MAX_SIZE);
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SIZE);

    // configuration
    logic [CFG_W-1:0] size_reg;
    logic [CFG_W-1:0] sz_eff;

    // per-level ring pointers
    logic [IDX_W-1:0] head_reg  [MAX_SIZE];
    logic [IDX_W-1:0] head_next [MAX_SIZE];
    logic [IDX_W-1:0] tail_reg  [MAX_SIZE];
    logic [IDX_W-1:0] tail_next [MAX_SIZE];
    logic [MAX_SIZE-1:0] empty_reg;
    logic [MAX_SIZE-1:0] empty_next;

    // lookup stage, waiting for ram read data
    logic             p_valid_reg;
    status_t          p_status_reg;
    status_t          p_status_next;
    logic [LEVEL_W-1:0] p_level_reg;
    logic [LEVEL_W-1:0] p_level_next;
    logic             p_del_ok_reg;
    logic             p_del_ok_next;
    logic             p_move;

    // output register
    logic             out_valid_reg;
    status_t          status_reg;
    logic [DATA_W-1:0] removed_value_reg;
    logic [LEVEL_W-1:0] removed_level_reg;

    logic             in_acc;
    logic             ins;
    logic             del;
    logic             prio_bad;
    logic [IDX_W-1:0] ins_lv;
    logic             ins_empty;
    logic [IDX_W-1:0] ins_nt;
    logic             ins_full;
    logic             del_found;
    logic [IDX_W-1:0] del_lv;
    logic [IDX_W-1:0] del_head;
    logic             del_last;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [IDX_W-1:0]  ram_wslot;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    function automatic logic [IDX_W-1:0] advance(
        input logic [IDX_W-1:0] idx,
        input logic [CFG_W-1:0] sz
    );
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(idx) + CMP_W'(1);
        if (inc >= CMP_W'(sz))
        begin
            return '0;
        end
        return IDX_W'(inc);
    endfunction

    // size clamped to 1..MAX_SIZE
    always_comb
    begin
        if (size_reg == '0)
        begin
            sz_eff = CFG_W'(1);
        end
        else if (CMP_W'(size_reg) > MAX_CMP)
        begin
            sz_eff = CFG_W'(MAX_SIZE);
        end
        else
        begin
            sz_eff = size_reg;
        end
    end

    assign p_move   = !out_valid_reg || !out_stall;
    assign in_stall = p_valid_reg && !p_move;
    assign in_acc   = in_valid && !in_stall;
    assign ins      = in_acc && (action == ACT_INSERT);
    assign del      = in_acc && (action == ACT_DELETE);

    assign prio_bad  = (priority_req == '0) || (priority_req > sz_eff);
    assign ins_lv    = IDX_W'(priority_req - PRIO_W'(1));
    assign ins_empty = empty_reg[ins_lv];
    assign ins_nt    = advance(tail_reg[ins_lv], sz_eff);
    assign ins_full  = !ins_empty && (ins_nt == head_reg[ins_lv]);

    // lowest-numbered non-empty level among those in use
    always_comb
    begin
        del_found = 1'b0;
        del_lv    = '0;
        for (int k = MAX_SIZE - 1; k >= 0; k--)
        begin
            if (!empty_reg[k] && (CMP_W'(k) < CMP_W'(sz_eff)))
            begin
                del_found = 1'b1;
                del_lv    = IDX_W'(k);
            end
        end
    end

    assign del_head = head_reg[del_lv];
    assign del_last = (del_head == tail_reg[del_lv]);

    // pointer update and transaction status
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        p_status_next = ST_OK;
        p_level_next  = '0;
        p_del_ok_next = 1'b0;
        ram_we        = 1'b0;
        ram_wslot     = '0;
        ram_re        = 1'b0;
        if (ins)
        begin
            if (prio_bad)
            begin
                p_status_next = ST_INVALID;
            end
            else if (ins_empty)
            begin
                head_next[ins_lv]  = '0;
                tail_next[ins_lv]  = '0;
                empty_next[ins_lv] = 1'b0;
                ram_we             = 1'b1;
            end
            else if (ins_full)
            begin
                p_status_next = ST_OVERFLOW;
            end
            else
            begin
                tail_next[ins_lv] = ins_nt;
                ram_we            = 1'b1;
                ram_wslot         = ins_nt;
            end
        end
        else if (del)
        begin
            if (!del_found)
            begin
                p_status_next = ST_UNDERFLOW;
            end
            else
            begin
                ram_re        = 1'b1;
                p_del_ok_next = 1'b1;
                p_level_next  = LEVEL_W'(del_lv) + LEVEL_W'(1);
                if (del_last)
                begin
                    empty_next[del_lv] = 1'b1;
                    head_next[del_lv]  = '0;
                    tail_next[del_lv]  = '0;
                end
                else
                begin
                    head_next[del_lv] = advance(del_head, sz_eff);
                end
            end
        end
    end

    assign ram_waddr = ADDR_W'(ins_lv) * ADDR_W'(MAX_SIZE) + ADDR_W'(ram_wslot);
    assign ram_raddr = ADDR_W'(del_lv) * ADDR_W'(MAX_SIZE) + ADDR_W'(del_head);

    mprq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SIZE * MAX_SIZE)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            empty_reg <= '1;
            for (int k = 0; k < MAX_SIZE; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            empty_reg <= empty_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_valid_reg && p_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_status_reg <= p_status_next;
            p_level_reg  <= p_level_next;
            p_del_ok_reg <= p_del_ok_next;
        end
        if (p_valid_reg && p_move)
        begin
            status_reg        <= p_status_reg;
            removed_level_reg <= p_level_reg;
            removed_value_reg <= p_del_ok_reg ? ram_rdata : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_value_reg;
    assign removed_level = removed_level_reg;

    // a held lookup stage must keep its read data until it moves on
    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && !p_move |=> $stable(ram_rdata))
        else $error("ring ram read data changed under a held transaction");

    // only a successful delete carries a value or a level
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |->
            (removed_value_reg == '0) && (removed_level_reg == '0))
        else $error("failed transaction carries a value or level");

    // an empty level always has its pointers parked at slot zero
    for (genvar g = 0; g < MAX_SIZE; g++)
    begin : g_empty_chk
        a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
            empty_reg[g] |-> (head_reg[g] == '0) && (tail_reg[g] == '0))
            else $error("empty level with pointers away from slot zero");
    end

endmodule : multilevel_priority_ring_queue_core
`default_nettype wire

/* rtl/core/mprq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mprq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mprq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : mprq_ram
`default_nettype wire
